// File: rtl/mbarp_pkg.sv
// shared constants, result type and helper functions of the record parser
package mbarp_pkg;

  localparam int COUNT_CHARS   = 3;
  localparam int NUMBER_DIGITS = 5;

  localparam int VALUE_W  = 16;
  localparam int REMAIN_W = 10;
  localparam int DIGIT_W  = 3;

  localparam logic [7:0] TYPE_BIN   = 8'h00;
  localparam logic [7:0] TYPE_ASC   = 8'h01;
  localparam logic [7:0] CHAR_COMMA = 8'h2c;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic KIND_BIN = 1'b0;
  localparam logic KIND_ASC = 1'b1;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               is_count;
    logic               record_kind;
    logic               last_of_record;
  } result_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  endfunction

  // acc * 10 + digit, wrapping at 16 bits
  function automatic logic [VALUE_W-1:0] times_ten_add(input logic [VALUE_W-1:0] acc,
                                                       input logic [7:0] b);
    logic [7:0] digit;
    digit = b - CHAR_ZERO;
    return (acc << 3) + (acc << 1) + {{(VALUE_W-8){1'b0}}, digit};
  endfunction

endpackage

// File: rtl/mbarp_in_if.sv
// byte stream channel: one raw byte or an end-of-stream mark per transaction
interface mbarp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_mark;

  modport source (output valid, output data_byte, output end_mark, input ready);
  modport sink (input valid, input data_byte, input end_mark, output ready);
endinterface

// File: rtl/mbarp_out_if.sv
// result channel: one decoded count or number per transaction
interface mbarp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] value;
  logic        is_count;
  logic        record_kind;
  logic        last_of_record;

  modport source (output valid, output value, output is_count, output record_kind,
                  output last_of_record, input ready);
  modport sink (input valid, input value, input is_count, input record_kind,
                input last_of_record, output ready);
endinterface

// File: rtl/mbarp_parser.sv
// record parser state and per-byte decode logic
module mbarp_parser
  import mbarp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] data_byte,
  input  logic       end_mark,
  output logic       res_valid,
  output result_t    res
);

  localparam logic [2:0] PH_WAIT      = 3'd0;
  localparam logic [2:0] PH_BIN_COUNT = 3'd1;
  localparam logic [2:0] PH_BIN_HIGH  = 3'd2;
  localparam logic [2:0] PH_BIN_LOW   = 3'd3;
  localparam logic [2:0] PH_ASC_COUNT = 3'd4;
  localparam logic [2:0] PH_ASC_NUM   = 3'd5;

  logic [2:0]          phase, phase_next;
  logic                kind, kind_next;
  logic [REMAIN_W-1:0] remaining, remaining_next;
  logic [VALUE_W-1:0]  accumulator, accumulator_next;
  logic [7:0]          high_byte, high_byte_next;
  logic [DIGIT_W-1:0]  digit_count, digit_count_next;
  logic                count_done, count_done_next;

  logic [REMAIN_W-1:0] rem_dec;
  logic [DIGIT_W-1:0]  digit_inc;
  logic [VALUE_W-1:0]  acc_step;
  logic [VALUE_W-1:0]  count_val;
  logic                byte_is_type;

  assign rem_dec      = remaining - REMAIN_W'(1);
  assign digit_inc    = digit_count + DIGIT_W'(1);
  assign acc_step     = times_ten_add(accumulator, data_byte);
  assign byte_is_type = (data_byte == TYPE_BIN) || (data_byte == TYPE_ASC);

  always_comb begin
    phase_next       = phase;
    kind_next        = kind;
    remaining_next   = remaining;
    accumulator_next = accumulator;
    high_byte_next   = high_byte;
    digit_count_next = digit_count;
    count_done_next  = count_done;
    res_valid        = 1'b0;
    res              = '0;
    count_val        = '0;

    if (end_mark) begin
      if (phase == PH_ASC_NUM) begin
        res_valid          = 1'b1;
        res.value          = accumulator;
        res.record_kind    = KIND_ASC;
        res.last_of_record = 1'b1;
      end
      phase_next       = PH_WAIT;
      accumulator_next = '0;
      digit_count_next = '0;
      remaining_next   = '0;
    end else begin
      unique case (phase)
        PH_BIN_COUNT: begin
          res_valid        = 1'b1;
          res.value        = {{(VALUE_W-8){1'b0}}, data_byte};
          res.is_count     = 1'b1;
          res.record_kind  = KIND_BIN;
          remaining_next   = (data_byte == 8'd0) ? REMAIN_W'(1)
                                                 : {{(REMAIN_W-8){1'b0}}, data_byte};
          accumulator_next = '0;
          digit_count_next = '0;
          phase_next       = PH_BIN_HIGH;
        end
        PH_BIN_HIGH: begin
          high_byte_next = data_byte;
          phase_next     = PH_BIN_LOW;
        end
        PH_BIN_LOW: begin
          res_valid          = 1'b1;
          res.value          = {high_byte, data_byte};
          res.record_kind    = KIND_BIN;
          res.last_of_record = (rem_dec == '0);
          remaining_next     = rem_dec;
          phase_next         = (rem_dec == '0) ? PH_WAIT : PH_BIN_HIGH;
        end
        PH_ASC_COUNT: begin
          count_val = accumulator;
          if (!count_done && is_digit(data_byte)) begin
            count_val        = acc_step;
            accumulator_next = acc_step;
          end else begin
            count_done_next = 1'b1;
          end
          digit_count_next = digit_inc;
          if (digit_inc >= DIGIT_W'(COUNT_CHARS)) begin
            res_valid        = 1'b1;
            res.value        = count_val;
            res.is_count     = 1'b1;
            res.record_kind  = KIND_ASC;
            remaining_next   = (count_val == '0) ? REMAIN_W'(1) : count_val[REMAIN_W-1:0];
            accumulator_next = '0;
            digit_count_next = '0;
            phase_next       = PH_ASC_NUM;
          end
        end
        PH_ASC_NUM: begin
          if (is_digit(data_byte)) begin
            if (digit_count < DIGIT_W'(NUMBER_DIGITS)) begin
              accumulator_next = acc_step;
              digit_count_next = digit_inc;
            end
          end else if (data_byte == CHAR_COMMA) begin
            res_valid          = 1'b1;
            res.value          = accumulator;
            res.record_kind    = KIND_ASC;
            res.last_of_record = (rem_dec == '0);
            remaining_next     = rem_dec;
            if (rem_dec == '0) begin
              phase_next = PH_WAIT;
            end
            accumulator_next = '0;
            digit_count_next = '0;
          end else if (byte_is_type) begin
            res_valid          = 1'b1;
            res.value          = accumulator;
            res.record_kind    = KIND_ASC;
            res.last_of_record = 1'b1;
            remaining_next     = '0;
            if (data_byte == TYPE_BIN) begin
              kind_next  = KIND_BIN;
              phase_next = PH_BIN_COUNT;
            end else begin
              kind_next        = KIND_ASC;
              phase_next       = PH_ASC_COUNT;
              accumulator_next = '0;
              digit_count_next = '0;
              count_done_next  = 1'b0;
            end
          end
        end
        default: begin
          if (data_byte == TYPE_BIN) begin
            kind_next  = KIND_BIN;
            phase_next = PH_BIN_COUNT;
          end else if (data_byte == TYPE_ASC) begin
            kind_next        = KIND_ASC;
            phase_next       = PH_ASC_COUNT;
            accumulator_next = '0;
            digit_count_next = '0;
            count_done_next  = 1'b0;
          end else begin
            phase_next = PH_WAIT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_WAIT;
      kind        <= KIND_BIN;
      remaining   <= '0;
      accumulator <= '0;
      high_byte   <= '0;
      digit_count <= '0;
      count_done  <= 1'b0;
    end else if (take) begin
      phase       <= phase_next;
      kind        <= kind_next;
      remaining   <= remaining_next;
      accumulator <= accumulator_next;
      high_byte   <= high_byte_next;
      digit_count <= digit_count_next;
      count_done  <= count_done_next;
    end
  end

  a_remaining_live: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BIN_HIGH || phase == PH_BIN_LOW || phase == PH_ASC_NUM) |-> remaining != '0)
    else $error("numbers pending with zero remaining");

  a_digit_bound: assert property (@(posedge clk) disable iff (rst)
    digit_count <= DIGIT_W'(NUMBER_DIGITS))
    else $error("digit count out of range");

  a_count_not_last: assert property (@(posedge clk) disable iff (rst)
    (take && res_valid && res.is_count) |-> !res.last_of_record)
    else $error("count marked as last number");

  a_end_flush: assert property (@(posedge clk) disable iff (rst)
    (take && end_mark) |=> (phase == PH_WAIT && accumulator == '0 && remaining == '0))
    else $error("end of stream did not return to idle");

endmodule

// File: rtl/mixed_binary_ascii_record_parser_top.sv
// top level of the mixed binary / ascii record parser
//
// bytes: one transaction per stream byte; end_mark high marks end of stream,
//   its data_byte is ignored and a pending ascii number is flushed
// results: one transaction per decoded count or number; is_count flags the
//   record's element count, record_kind gives binary or ascii, and
//   last_of_record flags the final number of a record
// every byte is decoded in the cycle it is taken; a result appears on the
//   results channel in the cycle after the byte that completes it
// throughput is one byte per cycle unless a held result stalls the bytes channel;
//   the single output register holds the result while the receiver has not taken it
// bytes that complete no result pass without occupying the output register
// when results.ready is low with a result held, bytes.ready drops until the
//   result is taken; the held result stays unchanged meanwhile
// synchronous reset returns the parser to waiting for a type byte, clears its
//   counters and drops any held result
module mixed_binary_ascii_record_parser_top
  import mbarp_pkg::*;
(
  input logic            clk,
  input logic            rst,
  mbarp_in_if.sink       bytes,
  mbarp_out_if.source    results
);

  logic    take;
  logic    res_valid;
  result_t res;
  logic    out_valid;
  result_t out_data;
  logic    room;

  assign room        = !out_valid || results.ready;
  assign bytes.ready = room;
  assign take        = bytes.valid && room;

  mbarp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (bytes.data_byte),
    .end_mark  (bytes.end_mark),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (room) begin
      out_valid <= take && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (room && take && res_valid) begin
      out_data <= res;
    end
  end

  assign results.valid          = out_valid;
  assign results.value          = out_data.value;
  assign results.is_count       = out_data.is_count;
  assign results.record_kind    = out_data.record_kind;
  assign results.last_of_record = out_data.last_of_record;

endmodule
